// ----- rtl/fsc_pkg.sv -----
`default_nettype none

package fsc_pkg;

  localparam logic [7:0] MagicByte    = 8'hE9;
  localparam logic [7:0] ChecksumSeed = 8'hEF;
  localparam logic [4:0] HdrSegCntIdx = 5'd1;
  localparam logic [4:0] HdrHashIdx   = 5'd23;
  localparam logic [2:0] SegHdrLast   = 3'd7;
  localparam logic [3:0] AlignLast    = 4'hF;
  localparam logic [5:0] DigestLen    = 6'd32;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    PH_SCAN,
    PH_HEADER,
    PH_SEGHDR,
    PH_SEGDATA,
    PH_PAD,
    PH_DIGEST
  } fsc_phase_e;

  // What the back end does with a byte.
  typedef enum logic [2:0] {
    KIND_PLAIN,
    KIND_MAGIC,
    KIND_HFLAG,
    KIND_DATA,
    KIND_CSUM
  } fsc_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    fsc_kind_e  kind;
    logic       hash;
    logic       trunc;
  } fsc_item_t;

endpackage

`default_nettype wire

// ----- rtl/fsc_front.sv -----
`default_nettype none

module fsc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_data_i,
  input  logic              in_last_i,
  output logic              push_o,
  output fsc_pkg::fsc_item_t item_o,
  input  logic              full_i
);
  import fsc_pkg::*;

  fsc_phase_e  phase_q, phase_d, phase_nx;
  logic [3:0]  align_q, align_d;
  logic [4:0]  hdr_idx_q, hdr_idx_d;
  logic [7:0]  segs_q, segs_d;
  logic [2:0]  shdr_idx_q, shdr_idx_d;
  logic [31:0] seg_left_q, seg_left_d;
  logic        hash_q, hash_d;
  logic [5:0]  dig_left_q, dig_left_d;
  logic        in_fire;

  assign in_ready_o = !full_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign push_o     = in_fire;

  // Next state of the parser.
  always_comb begin
    phase_nx   = phase_q;
    align_d    = align_q + 4'd1;
    hdr_idx_d  = hdr_idx_q;
    segs_d     = segs_q;
    shdr_idx_d = shdr_idx_q;
    seg_left_d = seg_left_q;
    hash_d     = hash_q;
    dig_left_d = dig_left_q;
    case (phase_q)
      PH_HEADER: begin
        if (hdr_idx_q == HdrSegCntIdx) begin
          segs_d = in_data_i;
        end
        if (hdr_idx_q == HdrHashIdx) begin
          hash_d = (in_data_i != 8'd0);
        end
        hdr_idx_d = hdr_idx_q + 5'd1;
        if (hdr_idx_q == HdrHashIdx) begin
          if (segs_q == 8'd0) begin
            phase_nx = PH_PAD;
          end else begin
            phase_nx   = PH_SEGHDR;
            shdr_idx_d = 3'd0;
          end
        end
      end
      PH_SEGHDR: begin
        if (shdr_idx_q == 3'd0) begin
          seg_left_d = 32'd0;
        end
        // Size bytes 4..7 land little-endian in their lanes.
        if (shdr_idx_q[2]) begin
          seg_left_d[8*shdr_idx_q[1:0] +: 8] = in_data_i;
        end
        shdr_idx_d = shdr_idx_q + 3'd1;
        if (shdr_idx_q == SegHdrLast) begin
          if (seg_left_d == 32'd0) begin
            segs_d = segs_q - 8'd1;
            phase_nx = (segs_q == 8'd1) ? PH_PAD : PH_SEGHDR;
          end else begin
            phase_nx = PH_SEGDATA;
          end
        end
      end
      PH_SEGDATA: begin
        seg_left_d = seg_left_q - 32'd1;
        if (seg_left_q == 32'd1) begin
          segs_d     = segs_q - 8'd1;
          shdr_idx_d = 3'd0;
          phase_nx   = (segs_q == 8'd1) ? PH_PAD : PH_SEGHDR;
        end
      end
      PH_PAD: begin
        if (align_q == AlignLast) begin
          if (hash_q) begin
            phase_nx   = PH_DIGEST;
            dig_left_d = DigestLen;
          end else begin
            phase_nx = PH_SCAN;
          end
        end
      end
      PH_DIGEST: begin
        dig_left_d = dig_left_q - 6'd1;
        if (dig_left_q == 6'd1) begin
          phase_nx = PH_SCAN;
        end
      end
      default: begin
        phase_nx = PH_SCAN;
        if (align_q == 4'd0 && in_data_i == MagicByte) begin
          phase_nx  = PH_HEADER;
          hdr_idx_d = HdrSegCntIdx;
          segs_d    = 8'd0;
          hash_d    = 1'b0;
        end
      end
    endcase

    phase_d = phase_nx;
    // End of file: start over at position zero.
    if (in_last_i) begin
      phase_d    = PH_SCAN;
      align_d    = 4'd0;
      hdr_idx_d  = 5'd0;
      segs_d     = 8'd0;
      shdr_idx_d = 3'd0;
      seg_left_d = 32'd0;
      hash_d     = 1'b0;
      dig_left_d = 6'd0;
    end
  end

  // Classify the byte for the back end.
  always_comb begin
    item_o.data  = in_data_i;
    item_o.last  = in_last_i;
    item_o.hash  = hash_q;
    item_o.kind  = KIND_PLAIN;
    item_o.trunc = in_last_i && (phase_nx == PH_HEADER || phase_nx == PH_SEGHDR ||
                                 phase_nx == PH_SEGDATA || phase_nx == PH_PAD);
    case (phase_q)
      PH_HEADER: begin
        if (hdr_idx_q == HdrHashIdx) begin
          item_o.kind = KIND_HFLAG;
        end
      end
      PH_SEGHDR: item_o.kind = KIND_PLAIN;
      PH_SEGDATA: item_o.kind = KIND_DATA;
      PH_PAD: begin
        if (align_q == AlignLast) begin
          item_o.kind = KIND_CSUM;
        end
      end
      PH_DIGEST: item_o.kind = KIND_PLAIN;
      default: begin
        if (align_q == 4'd0 && in_data_i == MagicByte) begin
          item_o.kind = KIND_MAGIC;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SCAN;
      align_q    <= 4'd0;
      hdr_idx_q  <= 5'd0;
      segs_q     <= 8'd0;
      shdr_idx_q <= 3'd0;
      seg_left_q <= 32'd0;
      hash_q     <= 1'b0;
      dig_left_q <= 6'd0;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      align_q    <= align_d;
      hdr_idx_q  <= hdr_idx_d;
      segs_q     <= segs_d;
      shdr_idx_q <= shdr_idx_d;
      seg_left_q <= seg_left_d;
      hash_q     <= hash_d;
      dig_left_q <= dig_left_d;
    end
  end

  a_digest_needs_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DIGEST |-> hash_q)
    else $error("digest phase without hash flag");

  a_segdata_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SEGDATA |-> seg_left_q != 32'd0)
    else $error("segment data phase with nothing left");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_last_i |=> phase_q == PH_SCAN && align_q == 4'd0)
    else $error("parser did not restart after last byte");

endmodule

`default_nettype wire

// ----- rtl/fsc_queue.sv -----
`default_nettype none

module fsc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fsc_pkg::fsc_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output fsc_pkg::fsc_item_t item_o,
  output logic               empty_o
);
  import fsc_pkg::*;

  fsc_item_t        entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- rtl/fsc_back.sv -----
`default_nettype none

module fsc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               regen_i,
  input  logic               empty_i,
  input  fsc_pkg::fsc_item_t item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               image_start_o,
  output logic               checksum_here_o,
  output logic [7:0]         computed_checksum_o,
  output logic               checksum_mismatch_o,
  output logic               hash_present_o,
  output logic               truncated_error_o,
  output logic               last_out_o
);
  import fsc_pkg::*;

  logic       valid_q;
  logic [7:0] csum_q, csum_d;
  logic [7:0] byte_q, byte_d;
  logic       start_q, start_d;
  logic       here_q, here_d;
  logic [7:0] comp_q, comp_d;
  logic       mism_q, mism_d;
  logic       hp_q, hp_d;
  logic       trunc_q, trunc_d;
  logic       last_q;
  logic       take;

  // Advance whenever the output register is free or being drained.
  assign take  = !empty_i && (!valid_q || out_ready_i);
  assign pop_o = take;

  always_comb begin
    byte_d  = item_i.data;
    start_d = 1'b0;
    here_d  = 1'b0;
    comp_d  = 8'd0;
    mism_d  = 1'b0;
    hp_d    = 1'b0;
    trunc_d = item_i.trunc;
    csum_d  = csum_q;
    case (item_i.kind)
      KIND_MAGIC: begin
        start_d = 1'b1;
        csum_d  = ChecksumSeed;
      end
      KIND_HFLAG: begin
        if (regen_i) begin
          byte_d = 8'd0;
        end
      end
      KIND_DATA: csum_d = csum_q ^ item_i.data;
      KIND_CSUM: begin
        here_d = 1'b1;
        comp_d = csum_q;
        mism_d = (item_i.data != csum_q);
        hp_d   = item_i.hash;
        if (regen_i) begin
          byte_d = csum_q;
        end
      end
      default: csum_d = csum_q;
    endcase
    if (item_i.last) begin
      csum_d = ChecksumSeed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      csum_q  <= ChecksumSeed;
    end else begin
      if (take) begin
        valid_q <= 1'b1;
        csum_q  <= csum_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q  <= byte_d;
      start_q <= start_d;
      here_q  <= here_d;
      comp_q  <= comp_d;
      mism_q  <= mism_d;
      hp_q    <= hp_d;
      trunc_q <= trunc_d;
      last_q  <= item_i.last;
    end
  end

  assign out_valid_o         = valid_q;
  assign out_byte_o          = byte_q;
  assign image_start_o       = start_q;
  assign checksum_here_o     = here_q;
  assign computed_checksum_o = comp_q;
  assign checksum_mismatch_o = mism_q;
  assign hash_present_o      = hp_q;
  assign truncated_error_o   = trunc_q;
  assign last_out_o          = last_q;

  a_mismatch_at_csum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (mism_q || hp_q) |-> here_q)
    else $error("checksum status outside checksum byte");

  a_start_not_csum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> !(start_q && here_q))
    else $error("magic byte flagged as checksum byte");

endmodule

`default_nettype wire

// ----- rtl/firmware_image_checksum_fixer.sv -----
`default_nettype none

// Streams a firmware file byte by byte and passes every byte on, one result per
// byte. Images start at 16-byte-aligned 0xE9 magic bytes; the XOR checksum (seed
// 0xEF) over all segment data is compared with the stored checksum byte and, with
// regenerate mode set, written over it while the header hash flag is output as
// zero. Throughput is one byte per clock while the output is not stalled: the
// parser front end and the checksum back end each do one small state update per
// byte, with a two-entry queue between them. Each byte passes through the queue
// and the back-end output register. The mode register should be written only
// while no bytes are in flight; it resets to regenerate mode. An error is flagged
// on the last byte when the file ends inside an image before its checksum.
module firmware_image_checksum_fixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [7:0] out_byte, [15:8] computed_checksum
  output logic [4:0]  m_axis_tuser_o,  // [0] image_start, [1] checksum_here,
                                       // [2] checksum_mismatch, [3] hash_present,
                                       // [4] truncated_error
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i       // regenerate_mode
);
  import fsc_pkg::*;

  logic      regen_q;
  logic      push, full, pop, empty;
  fsc_item_t front_item, queue_item;
  logic [7:0] out_byte, comp;
  logic      start, here, mism, hp, trunc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regen_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      regen_q <= cfg_data_i;
    end
  end

  fsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .push_o     (push),
    .item_o     (front_item),
    .full_i     (full)
  );

  fsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (queue_item),
    .empty_o (empty)
  );

  fsc_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .regen_i             (regen_q),
    .empty_i             (empty),
    .item_i              (queue_item),
    .pop_o               (pop),
    .out_valid_o         (m_axis_tvalid_o),
    .out_ready_i         (m_axis_tready_i),
    .out_byte_o          (out_byte),
    .image_start_o       (start),
    .checksum_here_o     (here),
    .computed_checksum_o (comp),
    .checksum_mismatch_o (mism),
    .hash_present_o      (hp),
    .truncated_error_o   (trunc),
    .last_out_o          (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {comp, out_byte};
  assign m_axis_tuser_o = {trunc, hp, mism, here, start};

endmodule

`default_nettype wire
